// ===== sv/bpc_pkg.sv =====
// Shared types and constants for the barometer pressure compensation core.
`default_nettype none

package bpc_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_SENS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_OFF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_TC     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_TC      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COMP_ENABLE = 3'd6;

    // Input item: one raw pressure / temperature conversion pair
    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } bpc_in_t;

    // Result item: compensated pressure and temperature
    typedef struct packed {
        logic signed [31:0] pressure_out;
        logic signed [19:0] temperature_out;
    } bpc_out_t;

endpackage

`default_nettype wire

// ===== sv/barometer_pressure_compensation_core.sv =====
// Pipelined second-order barometric pressure and temperature compensation core.
//
// Usage:
//   Input channel (in_valid, in_stall, in_item) carries one raw pressure and
//   raw temperature conversion pair per item. Output channel (out_valid,
//   out_stall, out_item) returns one compensated pressure (0.01 mbar, low 32
//   bits) and temperature (0.01 C) per item, in order.
//   The user must load the six calibration words and compensation enable via
//   cfg_write / cfg_index / cfg_data with no item in flight (not enforced).
// Stages and throughput:
//   Ten stages; out_valid is the valid bit of the tenth, the output register.
//   One item per cycle while out_stall is low: each stage holds at most one multiply
//   per path (25 x 25 at most) or a short add chain, and all stages advance together.
// Reset:
//   rst_n clears all stage valid bits and the calibration words to zero and
//   sets the compensation enable. No clearing pass is needed.
// Stall:
//   When out_stall is high the output stage holds its item. Earlier stages
//   keep filling empty slots; in_stall rises only when every stage is full.
`default_nettype none

module barometer_pressure_compensation_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Input channel
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire bpc_pkg::bpc_in_t                      in_item,
    // Output channel
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output bpc_pkg::bpc_out_t                          out_item,
    // Configuration port
    input  wire logic                                  cfg_write,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [bpc_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import bpc_pkg::*;

    localparam int STAGES = 10;

    // Calibration registers
    logic [15:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;
    logic        comp_reg;

    // Stage valid bits and load enables
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] load;

    // Stage 1: raw pressure and dT
    logic        [23:0] s1_d1_reg;
    logic signed [24:0] s1_dt_reg, s1_dt_next;
    // Stage 2: first-order products
    logic        [23:0] s2_d1_reg;
    logic signed [41:0] s2_mt_reg, s2_mt_next;
    logic signed [41:0] s2_mo_reg, s2_mo_next;
    logic signed [41:0] s2_ms_reg, s2_ms_next;
    logic signed [49:0] s2_mdd_reg, s2_mdd_next;
    // Stage 3: TEMP, OFF, SENS, TEMP2
    logic        [23:0] s3_d1_reg;
    logic signed [19:0] s3_temp_reg, s3_temp_next;
    logic signed [39:0] s3_off_reg, s3_off_next;
    logic signed [39:0] s3_sens_reg, s3_sens_next;
    logic        [16:0] s3_temp2_reg;
    // Stage 4: squares of the low-temperature distances
    logic        [23:0] s4_d1_reg;
    logic signed [19:0] s4_temp_reg;
    logic               s4_low_reg, s4_low_next;
    logic               s4_cold_reg, s4_cold_next;
    logic        [35:0] s4_aa_reg, s4_aa_next;
    logic        [35:0] s4_bb_reg, s4_bb_next;
    logic signed [39:0] s4_off_reg;
    logic signed [39:0] s4_sens_reg;
    logic signed [19:0] s4_tout_reg, s4_tout_next;
    // Stage 5: OFF2 and SENS2
    logic        [23:0] s5_d1_reg;
    logic               s5_low_reg;
    logic signed [39:0] s5_off_reg;
    logic signed [39:0] s5_sens_reg;
    logic signed [19:0] s5_tout_reg;
    logic        [39:0] s5_off2_reg, s5_off2_next;
    logic        [39:0] s5_sens2_reg, s5_sens2_next;
    // Stage 6: corrected OFF and SENS
    logic        [23:0] s6_d1_reg;
    logic signed [19:0] s6_tout_reg;
    logic signed [39:0] s6_off_reg, s6_off_next;
    logic signed [39:0] s6_sens_reg, s6_sens_next;
    // Stage 7: partial products of D1 * SENS
    logic signed [19:0] s7_tout_reg;
    logic signed [39:0] s7_off_reg;
    logic               s7_neg_reg;
    logic        [43:0] s7_plo_reg, s7_plo_next;
    logic signed [44:0] s7_phi_reg, s7_phi_next;
    // Stage 8: D1 * SENS / 2^21
    logic signed [19:0] s8_tout_reg;
    logic signed [39:0] s8_off_reg;
    logic signed [42:0] s8_q_reg, s8_q_next;
    // Stage 9: subtract OFF
    logic signed [19:0] s9_tout_reg;
    logic signed [43:0] s9_diff_reg, s9_diff_next;
    // Stage 10: output register
    logic signed [19:0] s10_tout_reg;
    logic signed [31:0] s10_p_reg, s10_p_next;

    // Intermediates
    logic signed [41:0] mt_bias, mo_bias, ms_bias;
    logic signed [41:0] mt_div, mo_div, ms_div;
    logic signed [20:0] dist_a, dist_b;
    logic signed [41:0] sq_a, sq_b;
    logic        [38:0] aa_x5;
    logic        [38:0] bb_x7;
    logic        [39:0] bb_x11;
    logic signed [63:0] prod_sum;
    logic signed [43:0] diff_bias;

    // Compute load enables: a stage may load unless it and every later stage are stalled full
    always_comb
    begin
        logic full;
        for (int k = 0; k < STAGES; k++)
        begin
            full = 1'b1;
            for (int j = k; j < STAGES; j++)
            begin
                full = full & valid_reg[j];
            end
            load[k] = !(full && out_stall);
        end
    end

    // Advance valid bits with the data
    always_comb
    begin
        valid_next = valid_reg;
        for (int k = 0; k < STAGES; k++)
        begin
            if (load[k])
            begin
                valid_next[k] = (k == 0) ? in_valid : valid_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // Stage datapath
    always_comb
    begin
        // dT = D2 - C5 * 256
        s1_dt_next = $signed({1'b0, in_item.raw_temperature})
                   - $signed({1'b0, c5_reg, 8'h00});

        // First-order products
        s2_mt_next  = s1_dt_reg * $signed({1'b0, c6_reg});
        s2_mo_next  = s1_dt_reg * $signed({1'b0, c4_reg});
        s2_ms_next  = s1_dt_reg * $signed({1'b0, c3_reg});
        s2_mdd_next = s1_dt_reg * s1_dt_reg;

        // Truncating divides by powers of two
        mt_bias = s2_mt_reg + (s2_mt_reg[41] ? 42'sd8388607 : 42'sd0);
        mo_bias = s2_mo_reg + (s2_mo_reg[41] ? 42'sd127 : 42'sd0);
        ms_bias = s2_ms_reg + (s2_ms_reg[41] ? 42'sd255 : 42'sd0);
        mt_div  = mt_bias >>> 23;
        mo_div  = mo_bias >>> 7;
        ms_div  = ms_bias >>> 8;
        s3_temp_next = 20'(mt_div) + 20'sd2000;
        s3_off_next  = 40'(mo_div) + $signed({8'h00, c2_reg, 16'h0000});
        s3_sens_next = 40'(ms_div) + $signed({9'h000, c1_reg, 15'h0000});

        // Distances below 20.00 C and -15.00 C, squared
        dist_a = $signed({s3_temp_reg[19], s3_temp_reg}) - 21'sd2000;
        dist_b = $signed({s3_temp_reg[19], s3_temp_reg}) + 21'sd1500;
        sq_a   = dist_a * dist_a;
        sq_b   = dist_b * dist_b;
        s4_aa_next   = sq_a[35:0];
        s4_bb_next   = sq_b[35:0];
        s4_low_next  = comp_reg && (s3_temp_reg < 20'sd2000);
        s4_cold_next = s3_temp_reg < -20'sd1500;
        s4_tout_next = s3_temp_reg
                     - (s4_low_next ? $signed({3'b000, s3_temp2_reg}) : 20'sd0);

        // OFF2 and SENS2
        aa_x5  = {1'b0, s4_aa_reg, 2'b00} + {3'b000, s4_aa_reg};
        bb_x7  = {s4_bb_reg, 3'b000} - {3'b000, s4_bb_reg};
        bb_x11 = {1'b0, s4_bb_reg, 3'b000} + {3'b000, s4_bb_reg, 1'b0}
               + {4'h0, s4_bb_reg};
        s5_off2_next  = 40'd0;
        s5_sens2_next = 40'd0;
        if (s4_low_reg)
        begin
            s5_off2_next  = {2'b00, aa_x5[38:1]}
                          + (s4_cold_reg ? {1'b0, bb_x7} : 40'd0);
            s5_sens2_next = {3'b000, aa_x5[38:2]}
                          + (s4_cold_reg ? {1'b0, bb_x11[39:1]} : 40'd0);
        end

        // Apply corrections
        s6_off_next  = s5_off_reg - $signed(s5_off2_reg);
        s6_sens_next = s5_sens_reg - $signed(s5_sens2_reg);

        // Split D1 * SENS into two narrow products
        s7_plo_next = s6_d1_reg * s6_sens_reg[19:0];
        s7_phi_next = $signed({1'b0, s6_d1_reg}) * $signed(s6_sens_reg[39:20]);

        // Recombine with the truncation bias folded in, then drop 21 bits
        prod_sum  = (64'(s7_phi_reg) <<< 20) + $signed({20'h00000, s7_plo_reg})
                  + (s7_neg_reg ? 64'sd2097151 : 64'sd0);
        s8_q_next = prod_sum[63:21];

        // Subtract OFF
        s9_diff_next = $signed({s8_q_reg[42], s8_q_reg})
                     - $signed({{4{s8_off_reg[39]}}, s8_off_reg});

        // Divide by 2^15 toward zero, keep low 32 bits
        diff_bias  = s9_diff_reg + (s9_diff_reg[43] ? 44'sd32767 : 44'sd0);
        s10_p_next = 32'(diff_bias >>> 15);
    end

    // Hold control state: valid bits and calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            c1_reg    <= '0;
            c2_reg    <= '0;
            c3_reg    <= '0;
            c4_reg    <= '0;
            c5_reg    <= '0;
            c6_reg    <= '0;
            comp_reg  <= 1'b1;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_PRESS_SENS:  c1_reg   <= cfg_data;
                    REG_PRESS_OFF:   c2_reg   <= cfg_data;
                    REG_SENS_TC:     c3_reg   <= cfg_data;
                    REG_OFF_TC:      c4_reg   <= cfg_data;
                    REG_REF_TEMP:    c5_reg   <= cfg_data;
                    REG_TEMP_SLOPE:  c6_reg   <= cfg_data;
                    REG_COMP_ENABLE: comp_reg <= cfg_data[0];
                    default:         ;
                endcase
            end
        end
    end

    // Advance payload registers
    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s1_d1_reg <= in_item.raw_pressure;
            s1_dt_reg <= s1_dt_next;
        end
        if (load[1])
        begin
            s2_d1_reg  <= s1_d1_reg;
            s2_mt_reg  <= s2_mt_next;
            s2_mo_reg  <= s2_mo_next;
            s2_ms_reg  <= s2_ms_next;
            s2_mdd_reg <= s2_mdd_next;
        end
        if (load[2])
        begin
            s3_d1_reg    <= s2_d1_reg;
            s3_temp_reg  <= s3_temp_next;
            s3_off_reg   <= s3_off_next;
            s3_sens_reg  <= s3_sens_next;
            s3_temp2_reg <= s2_mdd_reg[47:31];
        end
        if (load[3])
        begin
            s4_d1_reg   <= s3_d1_reg;
            s4_temp_reg <= s3_temp_reg;
            s4_low_reg  <= s4_low_next;
            s4_cold_reg <= s4_cold_next;
            s4_aa_reg   <= s4_aa_next;
            s4_bb_reg   <= s4_bb_next;
            s4_off_reg  <= s3_off_reg;
            s4_sens_reg <= s3_sens_reg;
            s4_tout_reg <= s4_tout_next;
        end
        if (load[4])
        begin
            s5_d1_reg    <= s4_d1_reg;
            s5_low_reg   <= s4_low_reg;
            s5_off_reg   <= s4_off_reg;
            s5_sens_reg  <= s4_sens_reg;
            s5_tout_reg  <= s4_tout_reg;
            s5_off2_reg  <= s5_off2_next;
            s5_sens2_reg <= s5_sens2_next;
        end
        if (load[5])
        begin
            s6_d1_reg   <= s5_d1_reg;
            s6_tout_reg <= s5_tout_reg;
            s6_off_reg  <= s6_off_next;
            s6_sens_reg <= s6_sens_next;
        end
        if (load[6])
        begin
            s7_tout_reg <= s6_tout_reg;
            s7_off_reg  <= s6_off_reg;
            s7_neg_reg  <= s6_sens_reg[39];
            s7_plo_reg  <= s7_plo_next;
            s7_phi_reg  <= s7_phi_next;
        end
        if (load[7])
        begin
            s8_tout_reg <= s7_tout_reg;
            s8_off_reg  <= s7_off_reg;
            s8_q_reg    <= s8_q_next;
        end
        if (load[8])
        begin
            s9_tout_reg <= s8_tout_reg;
            s9_diff_reg <= s9_diff_next;
        end
        if (load[9])
        begin
            s10_tout_reg <= s9_tout_reg;
            s10_p_reg    <= s10_p_next;
        end
    end

    // Drive ports
    assign in_stall                 = !load[0];
    assign out_valid                = valid_reg[STAGES-1];
    assign out_item.pressure_out    = s10_p_reg;
    assign out_item.temperature_out = s10_tout_reg;

`ifndef NO_ASSERTIONS
    // Input backs up only when every stage is full and the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&valid_reg && out_stall))
        else $error("input stalled while the pipeline has room");

    // Low-temperature correction only below 20.00 C with compensation on
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[3] && s4_low_reg) |-> (comp_reg && s4_temp_reg < 20'sd2000))
        else $error("low-temperature flag set outside its range");

    // No second-order terms leave stage five without the low-temperature flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[4] && !s5_low_reg) |-> (s5_off2_reg == 40'd0 && s5_sens2_reg == 40'd0))
        else $error("second-order terms without low-temperature flag");

    // An item that moves into the output stage is presented next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[STAGES-2] && load[STAGES-1]) |=> out_valid)
        else $error("item lost between last two stages");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_barometer_pressure_compensation_core.sv =====
// Self-checking testbench for the barometer pressure compensation core.
`default_nettype none

module tb_barometer_pressure_compensation_core;

    import bpc_pkg::*;

    // Run limits and traffic sizes
    localparam int CYCLE_LIMIT       = 200000;
    localparam int SETTLE_CYCLES     = 14;
    localparam int HOLD_CYCLES       = 300;
    localparam int HOLD_READINGS     = 40;
    localparam int READINGS_PER_MODE = 160;

    // Write to an index past the last register, which the core ignores
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    // Compensation scale factors and temperature thresholds
    localparam longint REF_TEMP_SCALE = 256;
    localparam longint SLOPE_DIV      = 8388608;
    localparam longint OFF_SCALE      = 65536;
    localparam longint OFF_TC_DIV     = 128;
    localparam longint SENS_SCALE     = 32768;
    localparam longint SENS_TC_DIV    = 256;
    localparam longint DT_SQ_DIV      = 64'sd2147483648;
    localparam longint PRESS_DIV      = 2097152;
    localparam longint PRESS_OUT_DIV  = 32768;
    localparam longint TEMP_ROOM      = 2000;
    localparam longint TEMP_COLD      = -1500;

    localparam logic [23:0] RAW_MAX = 24'hFFFFFF;

    logic clk = 1'b0;
    logic rst_n;

    logic                 in_valid;
    logic                 in_stall;
    bpc_in_t              in_item;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    bpc_out_t             out_item;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Calibration shadow, kept in step with every register write
    longint coef_sens     = 0;
    longint coef_off      = 0;
    longint coef_sens_tc  = 0;
    longint coef_off_tc   = 0;
    longint coef_ref_temp = 0;
    longint coef_slope    = 0;
    bit     comp_on       = 1'b1;

    // Predicted readings waiting for the core
    bpc_out_t pending_readings[$];

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_req        = 0;

    int cycles           = 0;
    int readings_sent    = 0;
    int readings_checked = 0;
    int mismatches       = 0;
    int calib_sets       = 0;
    int warm_count       = 0;
    int cool_count       = 0;
    int frigid_count     = 0;
    int uncomp_count     = 0;

    barometer_pressure_compensation_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Compute the compensated pressure and temperature for one raw pair
    function automatic bpc_out_t compensate_reading(input bpc_in_t item);
        longint   d1;
        longint   d2;
        longint   dt;
        longint   temp;
        longint   off;
        longint   sens;
        longint   temp2;
        longint   off2;
        longint   sens2;
        longint   a;
        longint   b;
        longint   p;
        bpc_out_t r;
        d1    = longint'(item.raw_pressure);
        d2    = longint'(item.raw_temperature);
        dt    = d2 - coef_ref_temp * REF_TEMP_SCALE;
        temp  = TEMP_ROOM + (dt * coef_slope) / SLOPE_DIV;
        off   = coef_off * OFF_SCALE + (coef_off_tc * dt) / OFF_TC_DIV;
        sens  = coef_sens * SENS_SCALE + (coef_sens_tc * dt) / SENS_TC_DIV;
        temp2 = 0;
        off2  = 0;
        sens2 = 0;
        // Second-order terms below room temperature, extra ones when very cold
        if (!comp_on) begin
            uncomp_count++;
        end
        else if (temp < TEMP_ROOM) begin
            a     = temp - TEMP_ROOM;
            temp2 = (dt * dt) / DT_SQ_DIV;
            off2  = 5 * (a * a) / 2;
            sens2 = 5 * (a * a) / 4;
            if (temp < TEMP_COLD) begin
                b     = temp - TEMP_COLD;
                off2  = off2 + 7 * (b * b);
                sens2 = sens2 + 11 * (b * b) / 2;
                frigid_count++;
            end
            else begin
                cool_count++;
            end
        end
        else begin
            warm_count++;
        end
        off  = off - off2;
        sens = sens - sens2;
        p    = (d1 * sens / PRESS_DIV - off) / PRESS_OUT_DIV;
        r.pressure_out    = p[31:0];
        r.temperature_out = 20'(temp - temp2);
        return r;
    endfunction

    // Write one register and mirror it in the shadow
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_PRESS_SENS:  coef_sens     = longint'(data);
            REG_PRESS_OFF:   coef_off      = longint'(data);
            REG_SENS_TC:     coef_sens_tc  = longint'(data);
            REG_OFF_TC:      coef_off_tc   = longint'(data);
            REG_REF_TEMP:    coef_ref_temp = longint'(data);
            REG_TEMP_SLOPE:  coef_slope    = longint'(data);
            REG_COMP_ENABLE: comp_on       = data[0];
            default: ;
        endcase
    endtask

    task automatic close_writes();
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_calibration(input logic [15:0] c1, input logic [15:0] c2,
                                    input logic [15:0] c3, input logic [15:0] c4,
                                    input logic [15:0] c5, input logic [15:0] c6,
                                    input logic [15:0] en_word);
        write_reg(REG_PRESS_SENS, c1);
        write_reg(REG_PRESS_OFF, c2);
        write_reg(REG_SENS_TC, c3);
        write_reg(REG_OFF_TC, c4);
        write_reg(REG_REF_TEMP, c5);
        write_reg(REG_TEMP_SLOPE, c6);
        write_reg(REG_COMP_ENABLE, en_word);
        close_writes();
        calib_sets++;
    endtask

    // Offer one raw pair, hold it until taken, then idle at random
    task automatic offer_reading(input logic [23:0] d1, input logic [23:0] d2);
        bpc_in_t item;
        item.raw_pressure    = d1;
        item.raw_temperature = d2;
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (in_stall);
        pending_readings.push_back(compensate_reading(item));
        readings_sent++;
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Offer a pair whose temperature reading sits at a given offset from reference
    task automatic offer_at_dt(input longint dt, input logic [23:0] d1);
        offer_reading(d1, 24'(coef_ref_temp * REF_TEMP_SCALE + dt));
    endtask

    task automatic end_traffic();
        in_valid <= 1'b0;
    endtask

    // Wait until every predicted reading has come back and the pipe is empty
    task automatic drain();
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] random_word();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0) return 16'h0000;
        if (pick == 1) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    task automatic load_random_calibration();
        logic [15:0] en_word;
        en_word    = 16'($urandom);
        en_word[0] = ($urandom_range(99) < 70);
        load_calibration(random_word(), random_word(), random_word(), random_word(),
                         random_word(), random_word(), en_word);
    endtask

    // Raw temperature: mostly anywhere, sometimes close to the reference point
    function automatic logic [23:0] random_raw_temp();
        longint d2;
        case ($urandom_range(7))
            0: return 24'h000000;
            1: return RAW_MAX;
            2, 3: begin
                d2 = coef_ref_temp * REF_TEMP_SCALE + $urandom_range(131072) - 65536;
                if (d2 < 0) d2 = 0;
                if (d2 > longint'(RAW_MAX)) d2 = longint'(RAW_MAX);
                return 24'(d2);
            end
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] random_raw_press();
        case ($urandom_range(9))
            0: return 24'h000000;
            1: return RAW_MAX;
            default: return 24'($urandom);
        endcase
    endfunction

    // Calibration words at reset: all zero, compensation on
    task automatic test_reset_state();
        offer_reading(24'h000000, 24'h000000);
        offer_reading(RAW_MAX, RAW_MAX);
        offer_reading(RAW_MAX, 24'h000000);
        offer_reading(24'h000000, RAW_MAX);
        end_traffic();
        drain();
    endtask

    // All-ones calibration, then compensation off through a wide enable word
    task automatic test_calibration_extremes();
        load_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'h0001);
        offer_reading(24'h000000, 24'h000000);
        offer_reading(RAW_MAX, 24'h000000);
        offer_reading(24'h000000, RAW_MAX);
        offer_reading(RAW_MAX, RAW_MAX);
        end_traffic();
        drain();
        load_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFE);
        offer_reading(RAW_MAX, 24'h000000);
        offer_reading(24'h000000, 24'h000000);
        end_traffic();
        drain();
    endtask

    // Typical calibration across the room and cold thresholds, then an ignored write and compensation off
    task automatic test_temperature_bands();
        longint edge_dt;
        load_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312,
                         16'h0001);
        offer_at_dt(0, 24'd9085466);
        edge_dt = SLOPE_DIV / coef_slope;
        offer_at_dt(-edge_dt, 24'd9085466);
        offer_at_dt(-edge_dt - 1, 24'd9085466);
        edge_dt = (TEMP_ROOM - TEMP_COLD) * SLOPE_DIV / coef_slope;
        offer_at_dt(-edge_dt, 24'd6000000);
        offer_at_dt(-edge_dt - 1, 24'd6000000);
        edge_dt = (TEMP_ROOM - TEMP_COLD + 1) * SLOPE_DIV / coef_slope;
        offer_at_dt(-edge_dt, 24'd6000000);
        offer_at_dt(-edge_dt - 1, 24'd6000000);
        offer_reading(24'd9085466, RAW_MAX);
        end_traffic();
        drain();
        // A write past the last register must leave the calibration alone
        write_reg(REG_NONE, 16'hFFFF);
        close_writes();
        offer_reading(24'd9085466, 24'd1000000);
        end_traffic();
        drain();
        write_reg(REG_COMP_ENABLE, 16'h0000);
        close_writes();
        offer_reading(24'd9085466, 24'd1000000);
        end_traffic();
        drain();
    endtask

    // Random pairs under two random calibrations at one idling mix
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        sender_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        repeat (2) begin
            load_random_calibration();
            repeat (count / 2) offer_reading(random_raw_press(), random_raw_temp());
            end_traffic();
            drain();
        end
    endtask

    // Long output hold while the sender keeps offering, so the pipe backs up
    task automatic test_output_hold();
        sender_idle_pct = 0;
        recv_stall_pct <= 0;
        load_random_calibration();
        hold_req <= hold_req + 1;
        repeat (HOLD_READINGS) offer_reading(random_raw_press(), random_raw_temp());
        end_traffic();
        drain();
    endtask

    // Receiver stall, with an occasional long hold on request
    int hold_seen = 0;
    int hold_left = 0;
    always @(posedge clk)
    begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // Compare each taken result with the oldest prediction
    always @(posedge clk)
    begin
        bpc_out_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected result pressure %0d temperature %0d",
                         $time, out_item.pressure_out, out_item.temperature_out);
                mismatches++;
            end
            else begin
                want = pending_readings.pop_front();
                readings_checked++;
                if (out_item.pressure_out !== want.pressure_out) begin
                    $display("%0t: pressure expected %0d actual %0d",
                             $time, want.pressure_out, out_item.pressure_out);
                    mismatches++;
                end
                if (out_item.temperature_out !== want.temperature_out) begin
                    $display("%0t: temperature expected %0d actual %0d",
                             $time, want.temperature_out, out_item.temperature_out);
                    mismatches++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d readings outstanding",
                     $time, pending_readings.size());
            $display("** barometer_pressure_compensation_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_calibration_extremes();
        test_temperature_bands();
        test_random_traffic(0, 0, READINGS_PER_MODE);
        test_random_traffic(54, 0, READINGS_PER_MODE);
        test_random_traffic(0, 54, READINGS_PER_MODE);
        test_random_traffic(36, 36, READINGS_PER_MODE);
        test_output_hold();

        $display("Sent %0d raw pairs, checked %0d results, %0d calibration loads, %0d cycles.",
                 readings_sent, readings_checked, calib_sets, cycles);
        $display("Bands: %0d warm, %0d cool, %0d below -15 C, %0d uncompensated; %0d errors.",
                 warm_count, cool_count, frigid_count, uncomp_count, mismatches);
        if (mismatches == 0 && pending_readings.size() == 0) begin
            $display("** barometer_pressure_compensation_core: PASSED **");
        end
        else begin
            $display("** barometer_pressure_compensation_core: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
